// File: design/va_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the voice allocator.
package va_pkg;

    localparam int NUM_VOICES = 16;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W      = $clog2(NUM_VOICES + 1);
    localparam int LIM_W      = (CNT_W > 5) ? CNT_W : 5;
    localparam int AGE_W      = 32;
    localparam int LIM_RESET  = (NUM_VOICES < 16) ? NUM_VOICES : 16;

    localparam logic [AGE_W-1:0] NOTE_SPAN = AGE_W'(128);
    localparam logic [7:0]       NOTE_NONE = 8'hFF;

    // event codes
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
    localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;
    localparam logic [1:0] FUNC_PANIC    = 2'd3;

    // voice modes
    localparam logic [2:0] MODE_MONO      = 3'd0;
    localparam logic [2:0] MODE_LEGATO    = 3'd1;
    localparam logic [2:0] MODE_RETRIGGER = 3'd2;
    localparam logic [2:0] MODE_POLY      = 3'd3;

    // steal modes
    localparam logic [2:0] STEAL_NONE     = 3'd0;
    localparam logic [2:0] STEAL_OLDEST   = 3'd1;
    localparam logic [2:0] STEAL_LOWEST   = 3'd2;
    localparam logic [2:0] STEAL_HIGHEST  = 3'd3;
    localparam logic [2:0] STEAL_QUIETEST = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_VOICE_MODE  = 2'd0;
    localparam logic [1:0] REG_STEAL_MODE  = 2'd1;
    localparam logic [1:0] REG_VOICE_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic             active;
        logic [6:0]       note;
        logic [6:0]       velocity;
        logic [4:0]       channel;
        logic [AGE_W-1:0] age;
    } voice_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic             init;
        logic             step;
        logic             mono;
        logic             note_on;
        logic             note_off;
        logic             all_off;
        logic             panic;
        logic [6:0]       note;
        logic [4:0]       channel;
        logic [CNT_W-1:0] limit;
        logic [2:0]       steal_mode;
        logic [7:0]       last_note;
    } scan_ctrl_t;

    typedef struct packed {
        logic              free_found;
        logic [VIDX_W-1:0] free_idx;
        logic              victim_found;
        logic [VIDX_W-1:0] victim_idx;
        logic [AGE_W-1:0]  victim_key;
        logic [CNT_W-1:0]  count;
    } scan_res_t;

endpackage

// File: design/va_cell.sv
`timescale 1ns / 1ps
// One voice slot of the rotating voice ring.
module va_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  va_pkg::cell_ctrl_t ctrl,
    input  va_pkg::voice_t     shift_in,
    input  va_pkg::voice_t     load_in,
    output va_pkg::voice_t     voice
);
    import va_pkg::*;

    voice_t voice_reg;
    voice_t voice_next;

    always_comb
    begin
        voice_next = voice_reg;
        priority if (ctrl.shift)
        begin
            voice_next = shift_in;
        end
        else if (ctrl.load)
        begin
            voice_next = load_in;
        end
        else if (ctrl.clear)
        begin
            voice_next.active = 1'b0;
        end
        else
        begin
            // hold the slot
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= '0;
        end
        else
        begin
            voice_reg <= voice_next;
        end
    end

    assign voice = voice_reg;

endmodule

// File: design/va_scan.sv
`timescale 1ns / 1ps
// Head of the voice ring: edits each passing voice and collects search results.
module va_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  va_pkg::scan_ctrl_t        ctrl,
    input  logic [va_pkg::VIDX_W-1:0] idx,
    input  va_pkg::voice_t            head,
    output va_pkg::voice_t            tail,
    output va_pkg::scan_res_t         res
);
    import va_pkg::*;

    scan_res_t        res_reg;
    scan_res_t        res_next;
    logic             in_lim;
    logic             chan_hit;
    logic             steal_ok;
    logic             better;
    logic [AGE_W-1:0] key;
    logic [AGE_W-1:0] bound;

    always_comb
    begin
        in_lim   = CNT_W'(idx) < ctrl.limit;
        chan_hit = (ctrl.channel == 5'd0) || (head.channel == ctrl.channel);

        // edit the voice on its way back into the ring
        tail = head;
        priority if (ctrl.panic)
        begin
            tail = '0;
        end
        else if (ctrl.all_off)
        begin
            if (chan_hit)
            begin
                tail.active = 1'b0;
            end
        end
        else if (ctrl.note_off)
        begin
            if (ctrl.mono)
            begin
                if (idx == '0 && ctrl.last_note == {1'b0, ctrl.note})
                begin
                    tail.active = 1'b0;
                end
            end
            else if (in_lim && head.note == ctrl.note && chan_hit)
            begin
                tail.active = 1'b0;
            end
        end
        else
        begin
            // pass the voice through unchanged
        end

        steal_ok = (ctrl.steal_mode == STEAL_OLDEST) || (ctrl.steal_mode == STEAL_LOWEST)
                || (ctrl.steal_mode == STEAL_HIGHEST) || (ctrl.steal_mode == STEAL_QUIETEST);

        unique case (ctrl.steal_mode)
            STEAL_OLDEST:   key = head.age;
            STEAL_LOWEST:   key = AGE_W'(head.note);
            STEAL_HIGHEST:  key = AGE_W'(head.note);
            STEAL_QUIETEST: key = AGE_W'(head.velocity);
            default:        key = '0;
        endcase

        bound = res_reg.victim_found ? res_reg.victim_key : NOTE_SPAN;
        priority if (ctrl.steal_mode == STEAL_HIGHEST)
        begin
            better = !res_reg.victim_found || (key > res_reg.victim_key);
        end
        else if (ctrl.steal_mode == STEAL_OLDEST)
        begin
            better = !res_reg.victim_found || (key < res_reg.victim_key);
        end
        else
        begin
            better = key < bound;
        end

        res_next = res_reg;
        priority if (ctrl.init)
        begin
            res_next = '0;
        end
        else if (ctrl.step)
        begin
            if (in_lim && tail.active)
            begin
                res_next.count = res_reg.count + CNT_W'(1);
            end
            if (ctrl.note_on && !ctrl.mono && in_lim)
            begin
                if (!head.active && !res_reg.free_found)
                begin
                    res_next.free_found = 1'b1;
                    res_next.free_idx   = idx;
                end
                if (head.active && steal_ok && better)
                begin
                    res_next.victim_found = 1'b1;
                    res_next.victim_idx   = idx;
                    res_next.victim_key   = key;
                end
            end
        end
        else
        begin
            // hold the collected results
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: design/synth_voice_allocator.sv
`timescale 1ns / 1ps
// Top level of the polyphonic voice allocator with voice stealing.
//
// Usage:
//   Input channel: drive func, note, velocity and channel and raise start;
//   the transaction is taken at a rising edge where start is high and busy
//   is low. Events are note on (velocity zero acts as note off), note off,
//   all notes off and panic.
//   Result channel: done is high for exactly one cycle with voice_valid,
//   voice_index, stolen, active_count and peak_count. The receiver cannot
//   stall; each result must be taken in the cycle it is shown.
//   Timing: every event rotates the ring of NUM_VOICES voice cells once
//   through the scan head (one voice per cycle), then writes the chosen
//   voice in the apply state. done is registered from the apply state and
//   the result is taken at the next edge; busy drops in the same cycle, so
//   a new event may be taken while done is shown, and not before.
//   Configuration: cfg_we with cfg_index / cfg_data writes voice_mode,
//   steal_mode or voice_limit; write only while idle.
//   Reset: all voices silent and cleared, poly mode, steal oldest, limit 16.
module synth_voice_allocator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [6:0] note,
    input  logic [6:0] velocity,
    input  logic [4:0] channel,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,
    output logic       done,
    output logic       voice_valid,
    output logic [3:0] voice_index,
    output logic       stolen,
    output logic [4:0] active_count,
    output logic [4:0] peak_count
);
    import va_pkg::*;

    // Sequencer and event registers
    state_t            state_reg, state_next;
    logic [VIDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [1:0]        func_reg;
    logic [6:0]        note_reg;
    logic [6:0]        vel_reg;
    logic [4:0]        chan_reg;

    // Configuration and global state
    logic [2:0]        mode_reg;
    logic [2:0]        steal_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [7:0]        last_note_reg, last_note_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;

    // Result registers
    logic              done_reg;
    logic              valid_reg, valid_next;
    logic [VIDX_W-1:0] idx_reg, idx_next;
    logic              stolen_reg, stolen_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Ring wiring
    voice_t            cell_q [NUM_VOICES];
    voice_t            tail;
    voice_t            load_entry;
    scan_ctrl_t        sctrl;
    scan_res_t         sres;

    logic              accept;
    logic              is_mono;
    logic              ev_on;
    logic              ev_off;
    logic              legato;
    logic              load_en;
    logic [VIDX_W-1:0] load_idx;
    logic              mode_change;
    logic [LIM_W-1:0]  lim_sat;
    logic [31:0]       idx_ext;
    logic [31:0]       count_ext;
    logic [31:0]       peak_ext;

    assign accept  = start && (state_reg == ST_IDLE);
    assign is_mono = mode_reg <= MODE_RETRIGGER;
    assign ev_on   = (func_reg == FUNC_NOTE_ON) && (vel_reg != 7'd0);
    assign ev_off  = (func_reg == FUNC_NOTE_OFF)
                  || ((func_reg == FUNC_NOTE_ON) && (vel_reg == 7'd0));
    assign legato  = (mode_reg == MODE_LEGATO) && (last_note_reg != NOTE_NONE);

    // Sequencer: idle, rotate the ring once, write back and report
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_idx_next = '0;
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + VIDX_W'(1);
                if (scan_idx_reg == VIDX_W'(NUM_VOICES - 1))
                begin
                    scan_idx_next = '0;
                    state_next    = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    // Latch the event on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            note_reg <= note;
            vel_reg  <= velocity;
            chan_reg <= channel;
        end
    end

    // Scan head control
    always_comb
    begin
        sctrl            = '0;
        sctrl.init       = accept;
        sctrl.step       = (state_reg == ST_SCAN);
        sctrl.mono       = is_mono;
        sctrl.note_on    = ev_on;
        sctrl.note_off   = ev_off;
        sctrl.all_off    = (func_reg == FUNC_ALL_OFF);
        sctrl.panic      = (func_reg == FUNC_PANIC);
        sctrl.note       = note_reg;
        sctrl.channel    = chan_reg;
        sctrl.limit      = limit_reg;
        sctrl.steal_mode = steal_reg;
        sctrl.last_note  = last_note_reg;
    end

    va_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sctrl),
        .idx   (scan_idx_reg),
        .head  (cell_q[0]),
        .tail  (tail),
        .res   (sres)
    );

    // Write-back: pick the voice, build its entry, update counts
    always_comb
    begin
        load_en        = 1'b0;
        load_idx       = '0;
        load_entry     = '0;
        last_note_next = last_note_reg;
        age_next       = age_reg;
        valid_next     = 1'b0;
        idx_next       = '0;
        stolen_next    = 1'b0;
        count_next     = sres.count;

        load_entry.active   = 1'b1;
        load_entry.note     = note_reg;
        load_entry.velocity = vel_reg;
        load_entry.channel  = chan_reg;
        load_entry.age      = age_reg;

        if (ev_on)
        begin
            if (is_mono)
            begin
                load_en        = 1'b1;
                valid_next     = 1'b1;
                last_note_next = {1'b0, note_reg};
                if (legato)
                begin
                    // keep gate, channel and stamp of voice 0
                    load_entry.active  = cell_q[0].active;
                    load_entry.channel = cell_q[0].channel;
                    load_entry.age     = cell_q[0].age;
                end
                else
                begin
                    age_next = age_reg + AGE_W'(1);
                    if (!cell_q[0].active)
                    begin
                        count_next = sres.count + CNT_W'(1);
                    end
                end
            end
            else if (sres.free_found)
            begin
                load_en    = 1'b1;
                load_idx   = sres.free_idx;
                valid_next = 1'b1;
                idx_next   = sres.free_idx;
                age_next   = age_reg + AGE_W'(1);
                count_next = sres.count + CNT_W'(1);
            end
            else if (sres.victim_found)
            begin
                load_en     = 1'b1;
                load_idx    = sres.victim_idx;
                valid_next  = 1'b1;
                idx_next    = sres.victim_idx;
                stolen_next = 1'b1;
                age_next    = age_reg + AGE_W'(1);
            end
        end
        else if (ev_off)
        begin
            if (is_mono && last_note_reg == {1'b0, note_reg})
            begin
                last_note_next = NOTE_NONE;
            end
        end
        else if (func_reg == FUNC_ALL_OFF)
        begin
            if (chan_reg == 5'd0)
            begin
                last_note_next = NOTE_NONE;
            end
        end
        else
        begin
            last_note_next = NOTE_NONE;
        end

        peak_next = (count_next > peak_reg) ? count_next : peak_reg;
    end

    // Configuration decode
    always_comb
    begin
        mode_change = cfg_we && (cfg_index == REG_VOICE_MODE) && (cfg_data[2:0] != mode_reg);
        lim_sat     = LIM_W'(cfg_data);
        if (lim_sat < LIM_W'(1))
        begin
            lim_sat = LIM_W'(1);
        end
        if (lim_sat > LIM_W'(NUM_VOICES))
        begin
            lim_sat = LIM_W'(NUM_VOICES);
        end
    end

    // Ring of voice cells; cell 0 feeds the scan head, the head feeds the last cell
    for (genvar k = 0; k < NUM_VOICES; k++)
    begin : g_cell
        voice_t     shift_src;
        logic       lim_clear;
        cell_ctrl_t cell_ctrl;

        if (k == NUM_VOICES - 1)
        begin : g_tail
            assign shift_src = tail;
        end
        else
        begin : g_link
            assign shift_src = cell_q[k + 1];
        end

        assign lim_clear = cfg_we && (cfg_index == REG_VOICE_LIMIT)
                        && (LIM_W'(k) >= lim_sat) && (LIM_W'(k) < LIM_W'(limit_reg));

        always_comb
        begin
            cell_ctrl.shift = (state_reg == ST_SCAN);
            cell_ctrl.load  = (state_reg == ST_APPLY) && load_en
                           && (load_idx == VIDX_W'(k));
            cell_ctrl.clear = mode_change || lim_clear;
        end

        va_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (shift_src),
            .load_in  (load_entry),
            .voice    (cell_q[k])
        );
    end

    // State: configuration writes, idle by user rule; event updates at write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_POLY;
            steal_reg     <= STEAL_OLDEST;
            limit_reg     <= CNT_W'(LIM_RESET);
            last_note_reg <= NOTE_NONE;
            age_reg       <= '0;
            peak_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VOICE_MODE:
                    begin
                        if (mode_change)
                        begin
                            mode_reg      <= cfg_data[2:0];
                            last_note_reg <= NOTE_NONE;
                        end
                    end
                    REG_STEAL_MODE:
                    begin
                        steal_reg <= cfg_data[2:0];
                    end
                    REG_VOICE_LIMIT:
                    begin
                        limit_reg <= CNT_W'(lim_sat);
                    end
                    default:
                    begin
                        // unmapped index: drop the write
                    end
                endcase
            end
            if (state_reg == ST_APPLY)
            begin
                last_note_reg <= last_note_next;
                age_reg       <= age_next;
                peak_reg      <= peak_next;
            end
        end
    end

    // Result registers: registered from the write-back and held until the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_APPLY)
        begin
            valid_reg  <= valid_next;
            idx_reg    <= idx_next;
            stolen_reg <= stolen_next;
            count_reg  <= count_next;
        end
    end

    assign idx_ext   = 32'(idx_reg);
    assign count_ext = 32'(count_reg);
    assign peak_ext  = 32'(peak_reg);

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign voice_valid  = valid_reg;
    assign voice_index  = idx_ext[3:0];
    assign stolen       = stolen_reg;
    assign active_count = count_ext[4:0];
    assign peak_count   = peak_ext[4:0];

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the voice allocator: directed table, random phases, local predictor.
module testbench;
    import va_pkg::*;

    // Codes outside the package: mode and steal values that the block treats
    // like one of the named ones, and the unused register slot.
    localparam logic [2:0] MODE_UNISON = 3'd4;
    localparam logic [2:0] MODE_SPARE  = 3'd7;
    localparam logic [2:0] STEAL_SPARE = 3'd7;
    localparam logic [1:0] REG_SPARE   = 2'd3;

    // Settle time after the last result before the end.
    localparam int SETTLE_CYCLES = NUM_VOICES + 4;
    localparam int PHASES        = 13;
    localparam int PHASE_EVENTS  = 50;

    // One result transaction, field by field.
    typedef struct packed {
        logic       valid;
        logic [3:0] voice;
        logic       stolen;
        logic [4:0] active;
        logic [4:0] peak;
    } assign_t;

    // One row of the directed table: either an event or a register write.
    typedef struct packed {
        logic       is_write;
        logic [1:0] fn;
        logic [6:0] nt;
        logic [6:0] vl;
        logic [4:0] ch;
        logic [1:0] reg_sel;
        logic [4:0] reg_val;
        logic       has_want;
        assign_t    want;
    } directed_step_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] func;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [4:0] channel;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;
    logic       done;
    logic       voice_valid;
    logic [3:0] voice_index;
    logic       stolen;
    logic [4:0] active_count;
    logic [4:0] peak_count;

    synth_voice_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .note         (note),
        .velocity     (velocity),
        .channel      (channel),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .voice_valid  (voice_valid),
        .voice_index  (voice_index),
        .stolen       (stolen),
        .active_count (active_count),
        .peak_count   (peak_count)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the voice table and registers.
    // ------------------------------------------------------------------
    logic        vc_active [NUM_VOICES];
    logic [6:0]  vc_note   [NUM_VOICES];
    logic [6:0]  vc_vel    [NUM_VOICES];
    logic [4:0]  vc_chan   [NUM_VOICES];
    logic [31:0] vc_age    [NUM_VOICES];
    logic [31:0] note_seq;
    logic [7:0]  held_mono;
    logic [4:0]  peak_seen;
    logic [2:0]  cur_mode;
    logic [2:0]  cur_steal;
    int          cur_limit;

    // Assignments still owed by the block, oldest first.
    assign_t        assignments_due[$];
    directed_step_t directed_rows[$];

    // Side channel from the driver: a directed row may carry its own answer.
    logic    row_has_want;
    assign_t row_want;

    int mismatches       = 0;
    int events_accepted  = 0;
    int results_checked  = 0;
    int steals_expected  = 0;
    int drops_expected   = 0;
    int writes_done      = 0;

    task automatic report_failure(input string msg);
        $display("ERROR t=%0t result %0d: %s", $realtime, results_checked, msg);
        mismatches++;
    endtask

    function automatic void wipe_entries();
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            vc_active[i] = 1'b0;
            vc_note[i]   = '0;
            vc_vel[i]    = '0;
            vc_chan[i]   = '0;
            vc_age[i]    = '0;
        end
        held_mono = NOTE_NONE;
    endfunction

    function automatic void reset_table();
        wipe_entries();
        note_seq  = '0;
        peak_seen = '0;
        cur_mode  = MODE_POLY;
        cur_steal = STEAL_OLDEST;
        cur_limit = LIM_RESET;
    endfunction

    function automatic bit mono_mode();
        return cur_mode <= MODE_RETRIGGER;
    endfunction

    function automatic bit chan_hit(input logic [4:0] ch, input int v);
        return ch == 5'd0 || vc_chan[v] == ch;
    endfunction

    function automatic void open_voice(input int v, input logic [6:0] nt,
                                       input logic [6:0] vl, input logic [4:0] ch);
        vc_active[v] = 1'b1;
        vc_note[v]   = nt;
        vc_vel[v]    = vl;
        vc_chan[v]   = ch;
        vc_age[v]    = note_seq;
        note_seq     = note_seq + 32'd1;
    endfunction

    function automatic void apply_write(input logic [1:0] sel, input logic [4:0] val);
        int lim;
        case (sel)
            REG_VOICE_MODE:
            begin
                // A real mode change silences everything; rewriting the same mode is a no-op.
                if (val[2:0] != cur_mode)
                begin
                    cur_mode = val[2:0];
                    for (int i = 0; i < NUM_VOICES; i++)
                        vc_active[i] = 1'b0;
                    held_mono = NOTE_NONE;
                end
            end
            REG_STEAL_MODE:
                cur_steal = val[2:0];
            REG_VOICE_LIMIT:
            begin
                lim = int'(val);
                if (lim < 1)
                    lim = 1;
                if (lim > NUM_VOICES)
                    lim = NUM_VOICES;
                // Shrinking the limit cuts off voices above the new limit.
                for (int i = lim; i < cur_limit; i++)
                    vc_active[i] = 1'b0;
                cur_limit = lim;
            end
            default: ;
        endcase
    endfunction

    // Choose the voice to take over when every voice below the limit sounds.
    function automatic int steal_target();
        int          best;
        logic [31:0] key;
        logic [31:0] k;
        bit          better;
        best = -1;
        key  = '0;
        if (cur_steal < STEAL_OLDEST || cur_steal > STEAL_QUIETEST)
            return -1;
        for (int i = 0; i < cur_limit; i++)
        begin
            if (vc_active[i])
            begin
                case (cur_steal)
                    STEAL_OLDEST:  k = vc_age[i];
                    STEAL_LOWEST:  k = 32'(vc_note[i]);
                    STEAL_HIGHEST: k = 32'(vc_note[i]);
                    default:       k = 32'(vc_vel[i]);
                endcase
                // Strict compares keep the lowest index on ties.
                if (cur_steal == STEAL_HIGHEST)
                    better = best < 0 || k > key;
                else
                    better = best < 0 || k < key;
                if (better)
                begin
                    best = i;
                    key  = k;
                end
            end
        end
        return best;
    endfunction

    // Advance the predicted voice table by one event and return the assignment.
    function automatic assign_t predict_voice_event(input logic [1:0] fn, input logic [6:0] nt,
                                                    input logic [6:0] vl, input logic [4:0] ch);
        assign_t r;
        int      v;
        int      cnt;
        r   = '0;
        cnt = 0;
        if (fn == FUNC_NOTE_ON && vl != 7'd0)
        begin
            if (mono_mode())
            begin
                // Legato with a held note only bends pitch and level of voice 0.
                if (cur_mode == MODE_LEGATO && held_mono != NOTE_NONE)
                begin
                    vc_note[0] = nt;
                    vc_vel[0]  = vl;
                end
                else
                    open_voice(0, nt, vl, ch);
                held_mono = {1'b0, nt};
                r.valid   = 1'b1;
            end
            else
            begin
                v = -1;
                for (int i = 0; i < cur_limit; i++)
                    if (!vc_active[i] && v < 0)
                        v = i;
                if (v < 0)
                begin
                    v = steal_target();
                    if (v >= 0)
                        r.stolen = 1'b1;
                end
                if (v >= 0)
                begin
                    open_voice(v, nt, vl, ch);
                    r.valid = 1'b1;
                    r.voice = v[3:0];
                end
            end
        end
        else if (fn == FUNC_NOTE_ON || fn == FUNC_NOTE_OFF)
        begin
            // Mono release ignores the channel and needs the held note.
            if (mono_mode())
            begin
                if (held_mono == {1'b0, nt})
                begin
                    vc_active[0] = 1'b0;
                    held_mono    = NOTE_NONE;
                end
            end
            else
                for (int i = 0; i < cur_limit; i++)
                    if (vc_active[i] && vc_note[i] == nt && chan_hit(ch, i))
                        vc_active[i] = 1'b0;
        end
        else if (fn == FUNC_ALL_OFF)
        begin
            // All notes off sweeps the whole table, not just below the limit.
            for (int i = 0; i < NUM_VOICES; i++)
                if (vc_active[i] && chan_hit(ch, i))
                    vc_active[i] = 1'b0;
            if (ch == 5'd0)
                held_mono = NOTE_NONE;
        end
        else
            wipe_entries();
        for (int i = 0; i < cur_limit; i++)
            if (vc_active[i])
                cnt++;
        if (cnt > int'(peak_seen))
            peak_seen = cnt[4:0];
        r.active = cnt[4:0];
        r.peak   = peak_seen;
        return r;
    endfunction

    task automatic compare_assignment(input assign_t got, input assign_t want);
        if (got.valid !== want.valid)
            report_failure($sformatf("voice_valid got %0b expected %0b", got.valid, want.valid));
        if (got.voice !== want.voice)
            report_failure($sformatf("voice_index got %0d expected %0d", got.voice, want.voice));
        if (got.stolen !== want.stolen)
            report_failure($sformatf("stolen got %0b expected %0b", got.stolen, want.stolen));
        if (got.active !== want.active)
            report_failure($sformatf("active_count got %0d expected %0d",
                                     got.active, want.active));
        if (got.peak !== want.peak)
            report_failure($sformatf("peak_count got %0d expected %0d", got.peak, want.peak));
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check the finished result first,
    // then apply a register write, then predict a newly accepted event, so a
    // result and the next acceptance landing on one edge stay in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        assign_t got;
        assign_t want;
        if (rst_n !== 1'b1)
        begin
            reset_table();
            assignments_due.delete();
        end
        else
        begin
            if (done === 1'b1)
            begin
                got.valid  = voice_valid;
                got.voice  = voice_index;
                got.stolen = stolen;
                got.active = active_count;
                got.peak   = peak_count;
                if (assignments_due.size() == 0)
                    report_failure("result strobe with no event outstanding");
                else
                    compare_assignment(got, assignments_due.pop_front());
                results_checked++;
            end
            if (cfg_we === 1'b1)
                apply_write(cfg_index, cfg_data);
            if (start === 1'b1 && busy === 1'b0)
            begin
                want = predict_voice_event(func, note, velocity, channel);
                // Directed rows with a hand-written answer override the predictor.
                if (row_has_want)
                    want = row_want;
                if (func == FUNC_NOTE_ON && velocity != 7'd0)
                begin
                    if (want.stolen)
                        steals_expected++;
                    if (!want.valid)
                        drops_expected++;
                end
                assignments_due.push_back(want);
                events_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. All of them start and end on a falling edge.
    // ------------------------------------------------------------------

    // Present one event and hold it until the block takes the transaction.
    // Start stays high on return so back-to-back events need no gap.
    task automatic offer_event(input logic [1:0] fn, input logic [6:0] nt, input logic [6:0] vl,
                               input logic [4:0] ch, input logic has_want, input assign_t want);
        func         = fn;
        note         = nt;
        velocity     = vl;
        channel      = ch;
        row_has_want = has_want;
        row_want     = want;
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // Drop start and hold until every owed result has come back.
    task automatic drain_results();
        start = 1'b0;
        while (assignments_due.size() != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] sel, input logic [4:0] val);
        drain_results();
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        writes_done++;
    endtask

    function automatic void add_event(input logic [1:0] fn, input logic [6:0] nt,
                                      input logic [6:0] vl, input logic [4:0] ch);
        directed_step_t s;
        s    = '0;
        s.fn = fn;
        s.nt = nt;
        s.vl = vl;
        s.ch = ch;
        directed_rows.push_back(s);
    endfunction

    function automatic void add_checked_event(input logic [1:0] fn, input logic [6:0] nt,
                                              input logic [6:0] vl, input logic [4:0] ch,
                                              input assign_t want);
        directed_step_t s;
        s          = '0;
        s.fn       = fn;
        s.nt       = nt;
        s.vl       = vl;
        s.ch       = ch;
        s.has_want = 1'b1;
        s.want     = want;
        directed_rows.push_back(s);
    endfunction

    function automatic void add_write(input logic [1:0] sel, input logic [4:0] val);
        directed_step_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.reg_sel  = sel;
        s.reg_val  = val;
        directed_rows.push_back(s);
    endfunction

    // Directed table. Hand answers stand only where they are obvious:
    // the first events after reset and the dropped notes.
    function automatic void build_directed_table();
        // Poly, steal oldest, limit 16 after reset. Field extremes first.
        add_checked_event(FUNC_NOTE_ON, 7'd0, 7'd127, 5'd1, {1'b1, 4'd0, 1'b0, 5'd1, 5'd1});
        add_checked_event(FUNC_NOTE_ON, 7'd127, 7'd1, 5'd16, {1'b1, 4'd1, 1'b0, 5'd2, 5'd2});
        // Zero velocity acts as a release.
        add_checked_event(FUNC_NOTE_ON, 7'd127, 7'd0, 5'd16, {1'b0, 4'd0, 1'b0, 5'd1, 5'd2});
        // Channel zero matches any channel.
        add_checked_event(FUNC_NOTE_OFF, 7'd0, 7'd0, 5'd0, {1'b0, 4'd0, 1'b0, 5'd0, 5'd2});
        // Two voices, then walk every steal policy.
        add_write(REG_VOICE_LIMIT, 5'd2);
        add_event(FUNC_NOTE_ON, 7'd60, 7'd64, 5'd31);
        add_event(FUNC_NOTE_ON, 7'd61, 7'd10, 5'd17);
        add_event(FUNC_NOTE_ON, 7'd62, 7'd100, 5'd3);
        add_write(REG_STEAL_MODE, STEAL_LOWEST);
        add_event(FUNC_NOTE_ON, 7'd5, 7'd90, 5'd3);
        add_write(REG_STEAL_MODE, STEAL_HIGHEST);
        add_event(FUNC_NOTE_ON, 7'd100, 7'd20, 5'd2);
        add_write(REG_STEAL_MODE, STEAL_QUIETEST);
        add_event(FUNC_NOTE_ON, 7'd30, 7'd127, 5'd2);
        // No stealing: a full table drops the note.
        add_write(REG_STEAL_MODE, STEAL_NONE);
        add_checked_event(FUNC_NOTE_ON, 7'd40, 7'd50, 5'd2, {1'b0, 4'd0, 1'b0, 5'd2, 5'd2});
        add_write(REG_STEAL_MODE, STEAL_SPARE);
        add_checked_event(FUNC_NOTE_ON, 7'd41, 7'd50, 5'd2, {1'b0, 4'd0, 1'b0, 5'd2, 5'd2});
        add_event(FUNC_ALL_OFF, 7'd0, 7'd0, 5'd17);
        // Limit saturates at both ends; the low end cuts off voice 1.
        add_write(REG_VOICE_LIMIT, 5'd0);
        add_write(REG_VOICE_LIMIT, 5'd31);
        add_event(FUNC_ALL_OFF, 7'd127, 7'd127, 5'd0);
        // Mono: release only on the held note, channel ignored.
        add_write(REG_VOICE_MODE, MODE_MONO);
        add_event(FUNC_NOTE_ON, 7'd72, 7'd80, 5'd4);
        add_event(FUNC_NOTE_OFF, 7'd73, 7'd0, 5'd4);
        add_event(FUNC_NOTE_OFF, 7'd72, 7'd0, 5'd9);
        // Legato, including a glide onto a silenced voice 0.
        add_write(REG_VOICE_MODE, MODE_LEGATO);
        add_event(FUNC_NOTE_ON, 7'd50, 7'd60, 5'd5);
        add_event(FUNC_NOTE_ON, 7'd52, 7'd70, 5'd6);
        add_event(FUNC_ALL_OFF, 7'd0, 7'd0, 5'd5);
        add_event(FUNC_NOTE_ON, 7'd55, 7'd30, 5'd5);
        // Same mode again must not clear the held note.
        add_write(REG_VOICE_MODE, MODE_LEGATO);
        add_event(FUNC_NOTE_OFF, 7'd55, 7'd0, 5'd5);
        add_write(REG_VOICE_MODE, MODE_RETRIGGER);
        add_event(FUNC_NOTE_ON, 7'd9, 7'd9, 5'd0);
        add_event(FUNC_PANIC, 7'd127, 7'd127, 5'd31);
        add_write(REG_VOICE_MODE, MODE_UNISON);
        add_event(FUNC_NOTE_ON, 7'd64, 7'd64, 5'd8);
        // Spare codes: mode 7 runs as poly, the unused slot writes nothing.
        add_write(REG_VOICE_MODE, MODE_SPARE);
        add_write(REG_SPARE, 5'd31);
        add_write(REG_VOICE_MODE, MODE_POLY);
        add_write(REG_STEAL_MODE, STEAL_OLDEST);
    endfunction

    // ------------------------------------------------------------------
    // Random phases: fresh settings, then a burst-shaped stream of events
    // drawn mostly from small note and channel pools so releases hit.
    // ------------------------------------------------------------------
    task automatic run_random_phase();
        logic [6:0] note_pool [8];
        logic [4:0] chan_pool [3];
        logic [2:0] mode_val;
        logic [2:0] steal_val;
        logic [4:0] limit_val;
        logic [1:0] fn;
        logic [6:0] nt;
        logic [6:0] vl;
        logic [4:0] ch;
        int         pick;
        int         burst;
        int         sent;
        bit         steady;

        pick = $urandom_range(0, 9);
        if (pick < 4)
            mode_val = 3'($urandom_range(MODE_MONO, MODE_RETRIGGER));
        else if (pick < 7)
            mode_val = MODE_POLY;
        else if (pick < 8)
            mode_val = MODE_UNISON;
        else
            mode_val = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 3) != 0)
            steal_val = 3'($urandom_range(STEAL_OLDEST, STEAL_QUIETEST));
        else
            steal_val = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            limit_val = 5'($urandom_range(1, 16));
        else if (pick < 7)
            limit_val = 5'd16;
        else if (pick < 8)
            limit_val = 5'd1;
        else if (pick < 9)
            limit_val = 5'd0;
        else
            limit_val = 5'($urandom_range(17, 31));
        write_register(REG_VOICE_MODE, 5'(mode_val));
        write_register(REG_STEAL_MODE, 5'(steal_val));
        write_register(REG_VOICE_LIMIT, limit_val);

        foreach (note_pool[i])
            note_pool[i] = 7'($urandom_range(0, 127));
        chan_pool[0] = 5'd0;
        chan_pool[1] = 5'($urandom_range(1, 16));
        chan_pool[2] = 5'($urandom_range(0, 31));
        // Some phases run flat out with start never dropped.
        steady = ($urandom_range(0, 3) == 0);

        sent = 0;
        while (sent < PHASE_EVENTS)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < PHASE_EVENTS; b++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    fn = FUNC_NOTE_ON;
                else if (pick < 88)
                    fn = FUNC_NOTE_OFF;
                else if (pick < 97)
                    fn = FUNC_ALL_OFF;
                else
                    fn = FUNC_PANIC;
                if ($urandom_range(0, 9) != 0)
                    nt = note_pool[$urandom_range(0, 7)];
                else
                    nt = 7'($urandom_range(0, 127));
                if ($urandom_range(0, 99) < 8)
                    vl = 7'd0;
                else
                    vl = 7'($urandom_range(1, 127));
                if ($urandom_range(0, 9) != 0)
                    ch = chan_pool[$urandom_range(0, 2)];
                else
                    ch = 5'($urandom_range(0, 31));
                offer_event(fn, nt, vl, ch, 1'b0, '0);
                sent++;
            end
            // Idle long enough to land anywhere in the block's scan.
            if (!steady)
            begin
                start = 1'b0;
                repeat ($urandom_range(0, 24)) @(negedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        directed_step_t s;
        int             guard;
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_NOTE_ON;
        note         = '0;
        velocity     = '0;
        channel      = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_VOICE_MODE;
        cfg_data     = '0;
        row_has_want = 1'b0;
        row_want     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        build_directed_table();
        while (directed_rows.size() != 0)
        begin
            s = directed_rows.pop_front();
            if (s.is_write)
                write_register(s.reg_sel, s.reg_val);
            else
                offer_event(s.fn, s.nt, s.vl, s.ch, s.has_want, s.want);
        end
        // Wait out the directed part so its answers are all in.
        drain_results();
        row_has_want = 1'b0;

        for (int p = 0; p < PHASES; p++)
            run_random_phase();

        // Drain with a bound, then allow the block's latency for strays.
        start = 1'b0;
        guard = 0;
        while ((assignments_due.size() != 0 || busy !== 1'b0) && guard < 1000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (assignments_due.size() != 0)
            report_failure($sformatf("%0d results never arrived", assignments_due.size()));

        $display("Covered %0d events over %0d register writes: %0d results checked,",
                 events_accepted, writes_done, results_checked);
        $display("  %0d voices stolen and %0d notes dropped.", steals_expected, drops_expected);
        if (mismatches == 0)
            $display("synth_voice_allocator test passed");
        else
            $display("synth_voice_allocator test failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #1000000;
        $display("synth_voice_allocator test failed");
        $finish;
    end

endmodule

// File: sim.f
design/va_pkg.sv
design/va_cell.sv
design/va_scan.sv
design/synth_voice_allocator.sv
tb/sv/testbench.sv
